// File: rtl/core/pwaf_pkg.sv
package pwaf_pkg;

    // Field and register widths
    localparam int TIME_W  = 31;
    localparam int WATTS_W = 12;
    localparam int WMS_W   = 22;
    localparam int EXP_W   = 13;
    localparam int AVG_W   = 16;
    localparam int START_W = 32;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    // Register map, as byte addresses
    localparam logic [ADDR_W-1:0] ADDR_WINDOW_MS        = 3'd0;
    localparam logic [ADDR_W-1:0] ADDR_EXPECTED_SAMPLES = 3'd4;

    // Register reset values
    localparam logic [WMS_W-1:0] WINDOW_MS_RST        = 22'd5000;
    localparam logic [EXP_W-1:0] EXPECTED_SAMPLES_RST = 13'd5;

    // Saturated average
    localparam logic [AVG_W-1:0] AVG_MAX = 16'hFFFF;

    typedef logic [TIME_W-1:0] time_t;
    typedef logic [AVG_W-1:0]  avg_t;

endpackage

// File: rtl/core/peak_window_average_finder.sv
// Peak window average finder.
// Input channel (s_*): one timestamped power sample per transaction; s_final_sample
// marks the last sample of a ride. Result channel (m_*): one transaction per ride,
// sent after the final sample, carrying the peak start time, the peak average
// (watts with 4 fraction bits), a peak-found flag and a FIFO overflow flag.
// Configuration: APB-style port, window_ms at 0x0, expected_samples at 0x4;
// write only while the block is idle.
// One sample at a time: s_ready is high only while idle. A sample is taken, the
// oldest entry is checked (each evicted entry adds a check and a read), the sample
// is appended, the bit-serial divider runs over the NW-bit dividend (NW = sum
// width + 4, 29 at the default parameters) and the best is updated; after a final
// sample the result is then loaded into the output register.
// The restoring divider gives one quotient bit a cycle; the FIFO memory has one
// registered read port, so each eviction waits for the new head entry to be read.
// Result: m_valid comes from a register and rises once the result is loaded.
// Reset (aresetn low, synchronous): empty window, no best, registers to defaults.
// Window memory contents are not cleared; only written entries are ever read.
// Receiver stall: a waiting result holds in the output register while the next
// samples are taken; a second final sample waits until the first result is taken.
module peak_window_average_finder #(
    parameter int WINDOW_DEPTH = 4096,
    parameter int POWER_BITS   = 12
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // sample channel
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [pwaf_pkg::TIME_W-1:0]      s_sample_time_ms,
    input  logic [pwaf_pkg::WATTS_W-1:0]     s_sample_watts,
    input  logic                             s_final_sample,
    // result channel
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_peak_found,
    output logic signed [pwaf_pkg::START_W-1:0] m_peak_start_ms,
    output logic [pwaf_pkg::AVG_W-1:0]       m_peak_average,
    output logic                             m_window_overflow,
    // configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pwaf_pkg::ADDR_W-1:0]      paddr,
    input  logic [pwaf_pkg::DATA_W-1:0]      pwdata,
    output logic [pwaf_pkg::DATA_W-1:0]      prdata,
    output logic                             pready
);

    // Derived widths
    localparam int PW = (POWER_BITS < pwaf_pkg::WATTS_W) ? POWER_BITS : pwaf_pkg::WATTS_W;
    localparam int CW = $clog2(WINDOW_DEPTH + 1);        // fill count
    localparam int HW = $clog2(WINDOW_DEPTH);            // memory index
    localparam int SW = PW + CW;                         // running sum
    localparam int NW = SW + 4;                          // dividend, sum * 16
    localparam int DW = (CW > pwaf_pkg::EXP_W) ? CW : pwaf_pkg::EXP_W; // divisor
    localparam int KW = $clog2(NW + 1);                  // divide step counter
    localparam int TW = pwaf_pkg::TIME_W;

    localparam logic [CW-1:0] DEPTH_C = CW'(WINDOW_DEPTH);
    localparam logic [HW-1:0] LAST_IX = HW'(WINDOW_DEPTH - 1);
    localparam logic [KW-1:0] STEPS   = KW'(NW);

    // Sequencer codes
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_APPEND = 3'd3;
    localparam logic [2:0] ST_DIV    = 3'd4;
    localparam logic [2:0] ST_UPDATE = 3'd5;
    localparam logic [2:0] ST_OUT    = 3'd6;

    // Window store
    logic [TW-1:0] mem_time  [WINDOW_DEPTH];
    logic [PW-1:0] mem_power [WINDOW_DEPTH];
    logic [TW-1:0] rd_time_reg;
    logic [PW-1:0] rd_power_reg;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [HW-1:0] head_reg, head_next;
    logic [SW-1:0] sum_reg, sum_next;
    logic          best_valid_reg, best_valid_next;
    pwaf_pkg::avg_t  best_avg_reg, best_avg_next;
    pwaf_pkg::time_t best_time_reg, best_time_next;
    logic          overflow_reg, overflow_next;

    pwaf_pkg::time_t t_reg, t_next;
    logic [PW-1:0] w_reg, w_next;
    logic          last_reg, last_next;

    logic [NW-1:0] num_reg, num_next;
    logic [DW-1:0] div_reg, div_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [KW-1:0] step_reg, step_next;

    logic [pwaf_pkg::WMS_W-1:0] window_ms_reg;
    logic [pwaf_pkg::EXP_W-1:0] expected_reg;

    logic          m_valid_reg, m_valid_next;
    logic          found_reg, found_next;
    logic [pwaf_pkg::START_W-1:0] start_reg, start_next;
    pwaf_pkg::avg_t avg_out_reg, avg_out_next;
    logic          ovf_out_reg, ovf_out_next;

    // Combinational helpers
    logic          s_accept;
    logic          mem_we;
    logic [HW-1:0] tail;
    logic [CW:0]   tail_sum;
    logic [TW:0]   expire_time;
    logic          expired;
    logic [CW-1:0] count_inc;
    logic [SW-1:0] sum_inc;
    logic [DW:0]   rem_shift;
    logic [DW:0]   rem_diff;
    pwaf_pkg::avg_t avg_sat;
    logic          cfg_write;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;

    assign expire_time = {1'b0, rd_time_reg} + (TW + 1)'(window_ms_reg);
    assign expired     = (count_reg != '0) && ({1'b0, t_reg} >= expire_time);

    assign tail_sum  = {{(CW + 1 - HW){1'b0}}, head_reg} + {1'b0, count_reg};
    assign tail      = (tail_sum >= (CW + 1)'(WINDOW_DEPTH)) ?
                       HW'(tail_sum - (CW + 1)'(WINDOW_DEPTH)) : HW'(tail_sum);
    assign count_inc = count_reg + CW'(1);
    assign sum_inc   = sum_reg + SW'(w_reg);
    assign mem_we    = (state_reg == ST_APPEND);

    // One restoring divide step
    assign rem_shift = {rem_reg, num_reg[NW-1]};
    assign rem_diff  = rem_shift - {1'b0, div_reg};

    assign avg_sat = (|num_reg[NW-1:pwaf_pkg::AVG_W]) ? pwaf_pkg::AVG_MAX
                                                      : num_reg[pwaf_pkg::AVG_W-1:0];

    // Window store: write at the tail, read the head every cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem_time[tail]  <= t_reg;
            mem_power[tail] <= w_reg;
        end
        rd_time_reg  <= mem_time[head_reg];
        rd_power_reg <= mem_power[head_reg];
    end

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        head_next       = head_reg;
        sum_next        = sum_reg;
        best_valid_next = best_valid_reg;
        best_avg_next   = best_avg_reg;
        best_time_next  = best_time_reg;
        overflow_next   = overflow_reg;
        t_next          = t_reg;
        w_next          = w_reg;
        last_next       = last_reg;
        num_next        = num_reg;
        div_next        = div_reg;
        rem_next        = rem_reg;
        step_next       = step_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        found_next      = found_reg;
        start_next      = start_reg;
        avg_out_next    = avg_out_reg;
        ovf_out_next    = ovf_out_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    t_next     = s_sample_time_ms;
                    w_next     = s_sample_watts[PW-1:0];
                    last_next  = s_final_sample;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                // head entry data is valid here
                if (expired || (count_reg == DEPTH_C)) begin
                    sum_next   = sum_reg - SW'(rd_power_reg);
                    head_next  = (head_reg == LAST_IX) ? '0 : head_reg + HW'(1);
                    count_next = count_reg - CW'(1);
                end
                if (expired) begin
                    state_next = ST_READ;
                end else begin
                    if (count_reg == DEPTH_C) begin
                        overflow_next = 1'b1;
                    end
                    state_next = ST_APPEND;
                end
            end
            ST_READ: begin
                // wait for the new head entry
                state_next = ST_CHECK;
            end
            ST_APPEND: begin
                count_next = count_inc;
                sum_next   = sum_inc;
                num_next   = {sum_inc, 4'b0000};
                div_next   = (DW'(count_inc) > DW'(expected_reg)) ? DW'(count_inc)
                                                                  : DW'(expected_reg);
                rem_next   = '0;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (!rem_diff[DW]) begin
                    rem_next = rem_diff[DW-1:0];
                    num_next = {num_reg[NW-2:0], 1'b1};
                end else begin
                    rem_next = rem_shift[DW-1:0];
                    num_next = {num_reg[NW-2:0], 1'b0};
                end
                step_next = step_reg + KW'(1);
                if (step_reg == STEPS - KW'(1)) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                // earliest sample with the strictly highest average wins
                if (!best_valid_reg || (avg_sat > best_avg_reg)) begin
                    best_avg_next   = avg_sat;
                    best_time_next  = t_reg;
                    best_valid_next = 1'b1;
                end
                state_next = last_reg ? ST_OUT : ST_IDLE;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    if ({1'b0, t_reg} >= (TW + 1)'(window_ms_reg)) begin
                        found_next   = 1'b1;
                        start_next   = {1'b0, best_time_reg} -
                                       pwaf_pkg::START_W'(window_ms_reg);
                        avg_out_next = best_avg_reg;
                    end else begin
                        found_next   = 1'b0;
                        start_next   = '0;
                        avg_out_next = '0;
                    end
                    ovf_out_next = overflow_reg;
                    // start a new ride
                    count_next      = '0;
                    head_next       = '0;
                    sum_next        = '0;
                    best_valid_next = 1'b0;
                    best_avg_next   = '0;
                    best_time_next  = '0;
                    overflow_next   = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            head_reg       <= '0;
            sum_reg        <= '0;
            best_valid_reg <= 1'b0;
            best_avg_reg   <= '0;
            best_time_reg  <= '0;
            overflow_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            head_reg       <= head_next;
            sum_reg        <= sum_next;
            best_valid_reg <= best_valid_next;
            best_avg_reg   <= best_avg_next;
            best_time_reg  <= best_time_next;
            overflow_reg   <= overflow_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload and datapath registers
    always_ff @(posedge aclk) begin
        t_reg       <= t_next;
        w_reg       <= w_next;
        last_reg    <= last_next;
        num_reg     <= num_next;
        div_reg     <= div_next;
        rem_reg     <= rem_next;
        step_reg    <= step_next;
        found_reg   <= found_next;
        start_reg   <= start_next;
        avg_out_reg <= avg_out_next;
        ovf_out_reg <= ovf_out_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_peak_found      = found_reg;
    assign m_peak_start_ms   = start_reg;
    assign m_peak_average    = avg_out_reg;
    assign m_window_overflow = ovf_out_reg;

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_ms_reg <= pwaf_pkg::WINDOW_MS_RST;
            expected_reg  <= pwaf_pkg::EXPECTED_SAMPLES_RST;
        end else if (cfg_write) begin
            unique case (paddr[2])
                pwaf_pkg::ADDR_WINDOW_MS[2]: begin
                    window_ms_reg <= pwdata[pwaf_pkg::WMS_W-1:0];
                end
                pwaf_pkg::ADDR_EXPECTED_SAMPLES[2]: begin
                    expected_reg <= pwdata[pwaf_pkg::EXP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            pwaf_pkg::ADDR_WINDOW_MS[2]: prdata = pwaf_pkg::DATA_W'(window_ms_reg);
            pwaf_pkg::ADDR_EXPECTED_SAMPLES[2]: prdata = pwaf_pkg::DATA_W'(expected_reg);
            default: prdata = '0;
        endcase
    end

endmodule
